@@ design/lca_pkg.sv @@
package lca_pkg;

  // Default sizing
  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 10;

  // Command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_BUILD = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;
  localparam logic [1:0] STAT_NOTBLT = 2'd3;

  // Register indexes
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_ROOT_NODE  = 1'b1;

  // Shared width of the node limit
  function automatic int count_width(input int max_nodes);
    int w;
    begin
      w = $clog2(max_nodes + 1);
      count_width = (w > 11) ? w : 11;
    end
  endfunction

endpackage

@@ design/lca_engine.sv @@
module lca_engine
  import lca_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF,
  parameter int NCW         = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     command,
  input  logic [9:0]     node_a,
  input  logic [9:0]     node_b,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic           ancestor_found,
  output logic [9:0]     ancestor_node,
  output logic [9:0]     ancestor_depth,
  input  logic [NCW-1:0] n_used,
  input  logic [9:0]     root_node
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int AW    = NW + 1;
  localparam int SLOTS = 2 * (MAX_NODES - 1);
  localparam int EW    = $clog2(SLOTS + 1);
  localparam int XW    = $clog2(SLOTS);
  localparam int LW    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int TW    = $clog2(MAX_NODES + 1);
  localparam int CW    = NW + LW;
  localparam int SKW   = NW + EW + NW;

  localparam logic [AW-1:0] NO_ANC  = {AW{1'b1}};
  localparam logic [AW-1:0] MAX_A   = AW'(MAX_NODES);
  localparam logic [EW-1:0] EMPTY   = {EW{1'b1}};
  localparam logic [LW-1:0] LV_TOP  = LW'(LIFT_LEVELS - 1);
  localparam logic [CW-1:0] CNT_END = {CW{1'b1}};

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WAIT = 5'd1;
  localparam logic [4:0] S_CLR  = 5'd2;
  localparam logic [4:0] S_A2   = 5'd3;
  localparam logic [4:0] S_A3   = 5'd4;
  localparam logic [4:0] S_A4   = 5'd5;
  localparam logic [4:0] S_WH   = 5'd6;
  localparam logic [4:0] S_WE   = 5'd7;
  localparam logic [4:0] S_WT   = 5'd8;
  localparam logic [4:0] S_WS   = 5'd9;
  localparam logic [4:0] S_WP   = 5'd10;
  localparam logic [4:0] S_F1   = 5'd11;
  localparam logic [4:0] S_F2   = 5'd12;
  localparam logic [4:0] S_F3   = 5'd13;
  localparam logic [4:0] S_Q1   = 5'd14;
  localparam logic [4:0] S_Q2   = 5'd15;
  localparam logic [4:0] S_LS   = 5'd16;
  localparam logic [4:0] S_L1   = 5'd17;
  localparam logic [4:0] S_L2   = 5'd18;
  localparam logic [4:0] S_M    = 5'd19;
  localparam logic [4:0] S_PS   = 5'd20;
  localparam logic [4:0] S_P1   = 5'd21;
  localparam logic [4:0] S_P2   = 5'd22;
  localparam logic [4:0] S_RS   = 5'd23;
  localparam logic [4:0] S_R1   = 5'd24;
  localparam logic [4:0] S_R2   = 5'd25;
  localparam logic [4:0] S_DONE = 5'd26;

  // Adjacency heads
  logic [EW-1:0] head_mem [MAX_NODES];
  logic          head_we;
  logic [NW-1:0] head_wa, head_ra;
  logic [EW-1:0] head_wd, head_rd;

  // Edge slots
  logic [EW-1:0] enx_mem [SLOTS];
  logic [NW-1:0] etg_mem [SLOTS];
  logic          e_we;
  logic [XW-1:0] e_wa, e_ra;
  logic [EW-1:0] e_wnx, enx_rd;
  logic [NW-1:0] e_wtg, etg_rd;

  // Node depths
  logic [NW-1:0] dep_mem [MAX_NODES];
  logic          dep_we;
  logic [NW-1:0] dep_wa, dep_ra, dep_wd, dep_rd;

  // Ancestor table, addressed {node, level}
  logic [AW-1:0] anc_mem [MAX_NODES << LW];
  logic          anc_we;
  logic [CW-1:0] anc_wa, anc_ra;
  logic [AW-1:0] anc_wd, anc_rd;

  // Walk stack
  logic [SKW-1:0] stk_mem [MAX_NODES];
  logic           stk_we;
  logic [NW-1:0]  stk_wa, stk_ra;
  logic [SKW-1:0] stk_wd, stk_rd;

  // Control state
  logic [4:0]    state, ret;
  logic [EW-1:0] fill;
  logic          built;
  logic [CW-1:0] cnt;
  logic          clr_full, clr_build, clr_quiet;
  logic [TW-1:0] top;

  // Working registers
  logic [9:0]    a_in, b_in;
  logic [NW-1:0] x, xd, y, fi, u, v, du, dv;
  logic [EW-1:0] e;
  logic [LW-1:0] lv;
  logic [AW-1:0] pu;
  logic [1:0]    r_status;
  logic          r_found;
  logic [NW-1:0] r_node, r_depth;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      enx_mem[e_wa] <= e_wnx;
      etg_mem[e_wa] <= e_wtg;
    end
    enx_rd <= enx_mem[e_ra];
    etg_rd <= etg_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_wa] <= dep_wd;
    dep_rd <= dep_mem[dep_ra];
  end

  always_ff @(posedge clk) begin
    if (anc_we) anc_mem[anc_wa] <= anc_wd;
    anc_rd <= anc_mem[anc_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  assign in_ready       = (state == S_IDLE) && !out_valid;
  assign status         = r_status;
  assign ancestor_found = r_found;
  assign ancestor_node  = 10'(r_node);
  assign ancestor_depth = 10'(r_depth);

  // Sequencer
  always_ff @(posedge clk) begin
    head_we <= 1'b0;
    e_we    <= 1'b0;
    dep_we  <= 1'b0;
    anc_we  <= 1'b0;
    stk_we  <= 1'b0;
    if (rst) begin
      state     <= S_CLR;
      ret       <= S_IDLE;
      cnt       <= '0;
      clr_full  <= 1'b1;
      clr_build <= 1'b0;
      clr_quiet <= 1'b1;
      fill      <= '0;
      built     <= 1'b0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            a_in      <= node_a;
            b_in      <= node_b;
            r_status  <= STAT_OK;
            r_found   <= 1'b0;
            r_node    <= '0;
            r_depth   <= '0;
            case (command)
              CMD_CLEAR: begin
                cnt       <= '0;
                clr_full  <= 1'b1;
                clr_build <= 1'b0;
                clr_quiet <= 1'b0;
                fill      <= '0;
                built     <= 1'b0;
                state     <= S_CLR;
              end
              CMD_ADD: begin
                if (NCW'(node_a) >= n_used || NCW'(node_b) >= n_used) begin
                  r_status <= STAT_RANGE;
                  state    <= S_DONE;
                end else if (({1'b0, fill} + (EW+1)'(2)) > (EW+1)'(SLOTS)) begin
                  r_status <= STAT_FULL;
                  state    <= S_DONE;
                end else begin
                  head_ra <= NW'(node_a);
                  ret     <= S_A2;
                  state   <= S_WAIT;
                end
              end
              CMD_BUILD: begin
                if (NCW'(root_node) >= n_used) begin
                  r_status <= STAT_RANGE;
                  state    <= S_DONE;
                end else begin
                  cnt       <= '0;
                  clr_full  <= 1'b0;
                  clr_build <= 1'b1;
                  clr_quiet <= 1'b0;
                  state     <= S_CLR;
                end
              end
              default: begin
                if (NCW'(node_a) >= n_used || NCW'(node_b) >= n_used) begin
                  r_status <= STAT_RANGE;
                  state    <= S_DONE;
                end else if (!built) begin
                  r_status <= STAT_NOTBLT;
                  state    <= S_DONE;
                end else begin
                  u      <= NW'(node_a);
                  v      <= NW'(node_b);
                  dep_ra <= NW'(node_a);
                  ret    <= S_Q1;
                  state  <= S_WAIT;
                end
              end
            endcase
          end
        end
        S_WAIT: state <= ret;
        // sweep the tables, one entry a cycle
        S_CLR: begin
          anc_we <= 1'b1;
          anc_wa <= cnt;
          anc_wd <= NO_ANC;
          if (cnt[LW-1:0] == '0) begin
            dep_we <= 1'b1;
            dep_wa <= cnt[CW-1:LW];
            dep_wd <= '0;
            if (clr_full) begin
              head_we <= 1'b1;
              head_wa <= cnt[CW-1:LW];
              head_wd <= EMPTY;
            end
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_END) begin
            if (clr_build) begin
              x       <= NW'(root_node);
              xd      <= '0;
              top     <= TW'(1);
              head_ra <= NW'(root_node);
              ret     <= S_WH;
              state   <= S_WAIT;
            end else if (clr_quiet) begin
              state <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // link slot a->b
        S_A2: begin
          e_we    <= 1'b1;
          e_wa    <= fill[XW-1:0];
          e_wnx   <= head_rd;
          e_wtg   <= NW'(b_in);
          head_we <= 1'b1;
          head_wa <= NW'(a_in);
          head_wd <= fill;
          fill    <= fill + 1'b1;
          state   <= S_A3;
        end
        S_A3: begin
          head_ra <= NW'(b_in);
          ret     <= S_A4;
          state   <= S_WAIT;
        end
        // link slot b->a
        S_A4: begin
          e_we    <= 1'b1;
          e_wa    <= fill[XW-1:0];
          e_wnx   <= head_rd;
          e_wtg   <= NW'(a_in);
          head_we <= 1'b1;
          head_wa <= NW'(b_in);
          head_wd <= fill;
          fill    <= fill + 1'b1;
          built   <= 1'b0;
          state   <= S_DONE;
        end
        S_WH: begin
          e     <= head_rd;
          state <= S_WE;
        end
        // next edge of the top frame, or pop
        S_WE: begin
          if (e >= fill) begin
            if (top == TW'(1)) begin
              if (LIFT_LEVELS == 1) begin
                built <= 1'b1;
                state <= S_DONE;
              end else begin
                lv    <= LW'(1);
                fi    <= '0;
                state <= S_F1;
              end
            end else begin
              top    <= top - 1'b1;
              stk_ra <= NW'(top - TW'(2));
              ret    <= S_WP;
              state  <= S_WAIT;
            end
          end else begin
            e_ra  <= e[XW-1:0];
            ret   <= S_WT;
            state <= S_WAIT;
          end
        end
        S_WT: begin
          e <= enx_rd;
          y <= etg_rd;
          if (NCW'(etg_rd) >= n_used) begin
            state <= S_WE;
          end else begin
            anc_ra <= {etg_rd, LW'(0)};
            ret    <= S_WS;
            state  <= S_WAIT;
          end
        end
        // visit a new child, push the parent frame
        S_WS: begin
          if (y == NW'(root_node) || anc_rd != NO_ANC) begin
            state <= S_WE;
          end else begin
            anc_we <= 1'b1;
            anc_wa <= {y, LW'(0)};
            anc_wd <= AW'(x);
            dep_we <= 1'b1;
            dep_wa <= y;
            dep_wd <= xd + 1'b1;
            if (top < TW'(MAX_NODES)) begin
              stk_we  <= 1'b1;
              stk_wa  <= NW'(top - 1'b1);
              stk_wd  <= {x, e, xd};
              x       <= y;
              xd      <= xd + 1'b1;
              top     <= top + 1'b1;
              head_ra <= y;
              ret     <= S_WH;
              state   <= S_WAIT;
            end else begin
              state <= S_WE;
            end
          end
        end
        S_WP: begin
          {x, e, xd} <= stk_rd;
          state      <= S_WE;
        end
        // lifting levels, one entry at a time
        S_F1: begin
          anc_ra <= {fi, LW'(lv - 1'b1)};
          ret    <= S_F2;
          state  <= S_WAIT;
        end
        S_F2, S_F3: begin
          if (state == S_F2 && anc_rd < MAX_A) begin
            anc_ra <= {NW'(anc_rd), LW'(lv - 1'b1)};
            ret    <= S_F3;
            state  <= S_WAIT;
          end else begin
            if (state == S_F3) begin
              anc_we <= 1'b1;
              anc_wa <= {fi, lv};
              anc_wd <= anc_rd;
            end
            if (fi == NW'(n_used - 1'b1)) begin
              fi <= '0;
              if (lv == LV_TOP) begin
                built <= 1'b1;
                state <= S_DONE;
              end else begin
                lv    <= lv + 1'b1;
                state <= S_F1;
              end
            end else begin
              fi    <= fi + 1'b1;
              state <= S_F1;
            end
          end
        end
        S_Q1: begin
          du     <= dep_rd;
          dep_ra <= v;
          ret    <= S_Q2;
          state  <= S_WAIT;
        end
        // put the deeper node in u
        S_Q2: begin
          if (du < dep_rd) begin
            u  <= v;
            v  <= u;
            du <= dep_rd;
            dv <= du;
          end else begin
            dv <= dep_rd;
          end
          lv    <= LV_TOP;
          state <= S_LS;
        end
        S_LS: begin
          anc_ra <= {u, lv};
          ret    <= S_L1;
          state  <= S_WAIT;
        end
        S_L1, S_L2: begin
          if (state == S_L1 && anc_rd < MAX_A) begin
            pu     <= anc_rd;
            dep_ra <= NW'(anc_rd);
            ret    <= S_L2;
            state  <= S_WAIT;
          end else begin
            if (state == S_L2 && dep_rd >= dv) u <= NW'(pu);
            if (lv == '0) begin
              state <= S_M;
            end else begin
              lv    <= lv - 1'b1;
              state <= S_LS;
            end
          end
        end
        S_M: begin
          if (u == v) begin
            r_found <= 1'b1;
            r_node  <= u;
            r_depth <= dv;
            state   <= S_DONE;
          end else begin
            lv    <= LV_TOP;
            state <= S_PS;
          end
        end
        S_PS: begin
          anc_ra <= {u, lv};
          ret    <= S_P1;
          state  <= S_WAIT;
        end
        S_P1: begin
          pu     <= anc_rd;
          anc_ra <= {v, lv};
          ret    <= S_P2;
          state  <= S_WAIT;
        end
        // lift both while their ancestors differ
        S_P2: begin
          if (pu < MAX_A && anc_rd < MAX_A && pu != anc_rd) begin
            u <= NW'(pu);
            v <= NW'(anc_rd);
          end
          if (lv == '0) begin
            state <= S_RS;
          end else begin
            lv    <= lv - 1'b1;
            state <= S_PS;
          end
        end
        S_RS: begin
          anc_ra <= {u, LW'(0)};
          ret    <= S_R1;
          state  <= S_WAIT;
        end
        S_R1: begin
          if (anc_rd >= MAX_A) begin
            state <= S_DONE;
          end else begin
            r_node <= NW'(anc_rd);
            dep_ra <= NW'(anc_rd);
            ret    <= S_R2;
            state  <= S_WAIT;
          end
        end
        S_R2: begin
          r_found <= 1'b1;
          r_depth <= dep_rd;
          state   <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/tree_lca_binary_lifting.sv @@
// Clear sweeps the tables, one table entry a cycle; add edge links a slot in each direction;
// query lifts the deeper node to the other's depth, then lifts both while their ancestors differ.
// Build: the same sweep but keeping the adjacency heads, then a depth-first walk over the stored
// edge slots, then the ancestor table is filled per node and level. One transaction at a time.
// Reset: control clears, then the same table sweep runs with input not ready.
module tree_lca_binary_lifting
  import lca_pkg::*;
#(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [9:0]  node_a,
  input  logic [9:0]  node_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        ancestor_found,
  output logic [9:0]  ancestor_node,
  output logic [9:0]  ancestor_depth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int NCW = count_width(MAX_NODES);

  logic [10:0]    node_count;
  logic [9:0]     root_node;
  logic [NCW-1:0] n_used;

  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 11'd1;
      root_node  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NODE_COUNT) node_count <= cfg_data;
      else root_node <= cfg_data[9:0];
    end
  end

  // Clamp the node count into 1..MAX_NODES
  always_comb begin
    if (node_count == '0) n_used = NCW'(1);
    else if (NCW'(node_count) > NCW'(MAX_NODES)) n_used = NCW'(MAX_NODES);
    else n_used = NCW'(node_count);
  end

  lca_engine #(
    .MAX_NODES  (MAX_NODES),
    .LIFT_LEVELS(LIFT_LEVELS),
    .NCW        (NCW)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .node_a        (node_a),
    .node_b        (node_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .ancestor_found(ancestor_found),
    .ancestor_node (ancestor_node),
    .ancestor_depth(ancestor_depth),
    .n_used        (n_used),
    .root_node     (root_node)
  );

endmodule
